[rtl/core/directory_entry_table_unit_assert.svh]
// assertion macros shared by the directory entry table checks
`ifndef DIRECTORY_ENTRY_TABLE_UNIT_ASSERT_SVH
`define DIRECTORY_ENTRY_TABLE_UNIT_ASSERT_SVH

// plain clocked property with active-low reset disable
`define DET_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// a stalled beat keeps valid high and its payload steady
`define DET_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

[rtl/core/det_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// det_pkg
// types and fixed field widths of the directory entry table
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int OP_W      = 2;
  localparam int KEY_W     = 64;
  localparam int LEN_W     = 8;
  localparam int INODE_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int FOUND_W   = 8;
  localparam int TOTAL_W   = 7;
  localparam int TOTAL_MAX = 127;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_PUT    = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

endpackage

[rtl/core/det_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// det_req_if
// request channel: one directory operation per beat
// ----------------------------------------------------------------------------
interface det_req_if import det_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   name_key;
  logic [LEN_W-1:0]   name_length;
  logic [INODE_W-1:0] inode_number;

  modport source (output valid, output operation, output name_key,
                  output name_length, output inode_number, input ready);
  modport sink   (input valid, input operation, input name_key,
                  input name_length, input inode_number, output ready);
endinterface

[rtl/core/det_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// det_rsp_if
// response channel: one result per beat
// ----------------------------------------------------------------------------
interface det_rsp_if import det_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FOUND_W-1:0]  found_inode;
  logic [TOTAL_W-1:0]  entry_total;

  modport source (output valid, output status, output found_inode,
                  output entry_total, input ready);
  modport sink   (input valid, input status, input found_inode,
                  input entry_total, output ready);
endinterface

[rtl/core/det_entry_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// det_entry_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module det_entry_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 72
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/directory_entry_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directory_entry_table_unit
// ordered directory table: lookup, put and delete over a single entry ram
// ----------------------------------------------------------------------------
// channel | dir | beat carries
// req_i   | in  | operation, name_key, name_length, inode_number
// rsp_o   | out | status, found_inode, entry_total
//
// with n entries held: a lookup or put scans up to n entries (one ram read
// each, read data registered), then the response beat is loaded in S_DONE
// once the output register is free; immediate answers go straight to S_DONE
// a delete matching at entry k scans k + 1 entries, then shifts n - k - 1
// entries, one read and one write per cycle
// one operation at a time; a new request is taken while a response waits
// reset empties the table at once: the entry count clears, the ram needs none
// ----------------------------------------------------------------------------
module directory_entry_table_unit import det_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int NAME_BYTES = 8,
  parameter int INODE_BITS = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  det_req_if.sink   req_i,
  det_rsp_if.source rsp_o
);

  localparam int AW      = $clog2(CAPACITY);
  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int NW      = 8 * NAME_BYTES;
  localparam int ENTRY_W = NW + INODE_BITS;

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [NW-1:0]        key_q;
  logic [INODE_BITS-1:0] inode_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  status_e              res_status_q, res_status_d;
  logic [FOUND_W-1:0]   res_inode_q, res_inode_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [FOUND_W-1:0]   out_inode_q, out_inode_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;
  logic                 load_req;

  logic [NW-1:0]        canon_key;
  logic                 keep;
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [ENTRY_W-1:0]   wr_data, rd_data;
  logic [NW-1:0]        rd_name;
  logic [INODE_BITS-1:0] rd_inode;
  logic                 hit, last;
  logic [CW-1:0]        shift_idx;

  // a name ends at its first zero byte
  always_comb begin
    keep      = 1'b1;
    canon_key = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      keep = keep && (req_i.name_key[8*b +: 8] != 8'h00);
      if (keep) begin
        canon_key[8*b +: 8] = req_i.name_key[8*b +: 8];
      end
    end
  end

  det_entry_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_name   = rd_data[INODE_BITS +: NW];
  assign rd_inode  = rd_data[INODE_BITS-1:0];
  // in S_SCAN and S_SHIFT, read data belongs to entry ptr_q - 1
  assign hit       = (rd_name == key_q);
  assign last      = (ptr_q == count_q);
  assign shift_idx = ptr_q - CW'(2);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    res_status_d = res_status_q;
    res_inode_d  = res_inode_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_inode_d  = out_inode_q;
    out_total_d  = out_total_q;
    load_req     = 1'b0;
    req_i.ready  = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = ptr_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = count_q[AW-1:0];
    wr_data      = {key_q, inode_q};

    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          load_req     = 1'b1;
          res_inode_d  = '0;
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
          case (op_e'(req_i.operation))
            OP_LOOKUP, OP_DELETE: begin
              if (count_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = CW'(1);
                state_d = S_SCAN;
              end
            end
            OP_PUT: begin
              if (req_i.name_length >= LEN_W'(NAME_BYTES)) begin
                res_status_d = ST_TOO_LONG;
              end else if (count_q == '0) begin
                // empty table: append straight away
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data      = {canon_key, INODE_BITS'(req_i.inode_number)};
                count_d      = CW'(1);
                res_status_d = ST_OK;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = CW'(1);
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_d = S_DONE;
          case (op_q)
            OP_LOOKUP: begin
              res_status_d = ST_OK;
              res_inode_d  = FOUND_W'(rd_inode);
            end
            OP_PUT: begin
              res_status_d = ST_EXISTS;
            end
            OP_DELETE: begin
              if (last) begin
                count_d      = count_q - CW'(1);
                res_status_d = ST_OK;
              end else begin
                rd_en   = 1'b1;
                ptr_d   = ptr_q + CW'(1);
                state_d = S_SHIFT;
              end
            end
            default: res_status_d = ST_NOT_FOUND;
          endcase
        end else if (last) begin
          state_d      = S_DONE;
          res_status_d = ST_NOT_FOUND;
          if (op_q == OP_PUT) begin
            if (count_q == CW'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              wr_en        = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = ST_OK;
            end
          end
        end else begin
          rd_en = 1'b1;
          ptr_d = ptr_q + CW'(1);
        end
      end

      S_SHIFT: begin
        // move entry ptr_q - 1 down to ptr_q - 2
        wr_en   = 1'b1;
        wr_addr = shift_idx[AW-1:0];
        wr_data = rd_data;
        if (last) begin
          count_d      = count_q - CW'(1);
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end else begin
          rd_en = 1'b1;
          ptr_d = ptr_q + CW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_inode_d  = res_inode_q;
          out_total_d  = TOTAL_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_req) begin
      op_q    <= op_e'(req_i.operation);
      key_q   <= canon_key;
      inode_q <= INODE_BITS'(req_i.inode_number);
    end
    res_status_q <= res_status_d;
    res_inode_q  <= res_inode_d;
    out_status_q <= out_status_d;
    out_inode_q  <= out_inode_d;
    out_total_q  <= out_total_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.found_inode = out_inode_q;
  assign rsp_o.entry_total = out_total_q;

endmodule

[rtl/core/det_port_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// det_port_monitor
// port-level checks on the directory entry table, bound to the top level
// ----------------------------------------------------------------------------
`include "directory_entry_table_unit_assert.svh"

module det_port_monitor import det_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [FOUND_W-1:0]  rsp_found_inode_i,
  input logic [TOTAL_W-1:0]  rsp_entry_total_i
);

  logic [STATUS_W+FOUND_W+TOTAL_W-1:0] rsp_beat;

  assign rsp_beat = {rsp_status_i, rsp_found_inode_i, rsp_entry_total_i};

  `DET_ASSERT_HOLD(a_rsp_hold, clk_i, rst_ni, rsp_valid_i, rsp_ready_i, rsp_beat, "rsp beat changed while stalled")

  // only a successful lookup carries an inode number
  `DET_ASSERT(a_inode_only_ok, clk_i, rst_ni, ((rsp_valid_i && (rsp_found_inode_i != '0)) |-> (rsp_status_i == ST_OK)), "inode number on a failed response")

  `DET_ASSERT(a_total_bound, clk_i, rst_ni, (rsp_valid_i |-> ((CAPACITY > TOTAL_MAX) || (rsp_entry_total_i <= TOTAL_W'(CAPACITY)))), "entry total above capacity")

  // ready drops after every accept: the unit takes one operation at a time
  `DET_ASSERT(a_busy_after_accept, clk_i, rst_ni, ((req_valid_i && req_ready_i) |=> !req_ready_i), "request taken in the cycle after an accept")

endmodule

bind directory_entry_table_unit det_port_monitor #(
  .CAPACITY (CAPACITY)
) u_port_monitor (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_found_inode_i (rsp_o.found_inode),
  .rsp_entry_total_i (rsp_o.entry_total)
);

[tb/det_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// det_table_checker
// watches request and response beats, keeps a shadow directory table and
// compares every response beat field by field with the predicted reply
// ----------------------------------------------------------------------------
module det_table_checker import det_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int NAME_BYTES = 8,
  parameter int INODE_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  det_req_if   req_mon,
  det_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   awaiting_o,
  output int   checked_o,
  output int   full_refusals_o,
  output int   peak_total_o
);

  typedef struct packed {
    status_e             status;
    logic [FOUND_W-1:0]  found_inode;
    logic [TOTAL_W-1:0]  entry_total;
  } dir_reply_t;

  logic [KEY_W-1:0] shadow_names  [CAPACITY];
  logic [31:0]      shadow_inodes [CAPACITY];
  int               shadow_count;
  dir_reply_t       replies_due [$];

  // name ends at the first zero byte and never runs past NAME_BYTES
  function automatic logic [KEY_W-1:0] trim_name(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] out;
    bit               ended;
    out   = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES && b < KEY_W / 8; b++) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) out[8*b +: 8] = raw[8*b +: 8];
    end
    return out;
  endfunction

  function automatic dir_reply_t apply_dir_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] raw_key,
                                              logic [LEN_W-1:0] len,
                                              logic [INODE_W-1:0] inode);
    dir_reply_t       reply;
    logic [KEY_W-1:0] key;
    logic [31:0]      inode_kept;
    int               hit;
    key        = trim_name(raw_key);
    inode_kept = 32'(inode) & ((32'd1 << INODE_BITS) - 32'd1);
    hit        = shadow_count;
    for (int i = shadow_count - 1; i >= 0; i--) begin
      if (shadow_names[i] == key) hit = i;
    end
    reply.status      = ST_NOT_FOUND;
    reply.found_inode = '0;
    case (op)
      OP_LOOKUP: begin
        if (hit < shadow_count) begin
          reply.status      = ST_OK;
          reply.found_inode = FOUND_W'(shadow_inodes[hit]);
        end
      end
      OP_PUT: begin
        if (len >= NAME_BYTES) begin
          reply.status = ST_TOO_LONG;
        end else if (hit < shadow_count) begin
          reply.status = ST_EXISTS;
        end else if (shadow_count >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          shadow_names[shadow_count]  = key;
          shadow_inodes[shadow_count] = inode_kept;
          shadow_count++;
          reply.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (hit < shadow_count) begin
          // close the gap so the order of later entries is kept
          for (int j = hit; j < shadow_count - 1; j++) begin
            shadow_names[j]  = shadow_names[j + 1];
            shadow_inodes[j] = shadow_inodes[j + 1];
          end
          shadow_count--;
          reply.status = ST_OK;
        end
      end
      default: ;
    endcase
    reply.entry_total = TOTAL_W'(shadow_count);
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dir_reply_t due;
    dir_reply_t fresh;
    if (!rst_ni) begin
      shadow_count    = 0;
      replies_due.delete();
      fail_count_o    = 0;
      checked_o       = 0;
      full_refusals_o = 0;
      peak_total_o    = 0;
    end else begin
      // response first: a beat taken on the same edge belongs to a later reply
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (replies_due.size() == 0) begin
          $error("response beat with no request waiting: status %0d", rsp_mon.status);
          fail_count_o++;
        end else begin
          due = replies_due.pop_front();
          checked_o++;
          if (rsp_mon.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, rsp_mon.status);
            fail_count_o++;
          end
          if (rsp_mon.found_inode !== due.found_inode) begin
            $error("found_inode: expected %0d, got %0d", due.found_inode,
                   rsp_mon.found_inode);
            fail_count_o++;
          end
          if (rsp_mon.entry_total !== due.entry_total) begin
            $error("entry_total: expected %0d, got %0d", due.entry_total,
                   rsp_mon.entry_total);
            fail_count_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        fresh = apply_dir_op(req_mon.operation, req_mon.name_key, req_mon.name_length,
                             req_mon.inode_number);
        replies_due.push_back(fresh);
        if (fresh.status == ST_FULL) full_refusals_o++;
        if (shadow_count > peak_total_o) peak_total_o = shadow_count;
      end
    end
    awaiting_o = replies_due.size();
  end

endmodule

[tb/tb_directory_entry_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directory_entry_table_unit
// drives lookups, puts, deletes and unknown op codes into the directory table with random
// gaps and response stalls; a side checker predicts and compares replies
// ----------------------------------------------------------------------------
module tb_directory_entry_table_unit;
  import det_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int NAME_BYTES   = 8;
  localparam int INODE_BITS   = 8;
  localparam int POOL_SIZE    = 72;
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASE_ITEMS  = 180;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

  // the op field is two bits wide; the last code has no operation behind it
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  localparam logic [KEY_W-1:0] NAME_A       = 64'h0000_0000_0000_0061;
  localparam logic [KEY_W-1:0] NAME_A_JUNK  = 64'hDEAD_BEEF_CAFE_0061;
  localparam logic [KEY_W-1:0] NAME_B       = 64'h0000_0000_0000_0062;
  localparam logic [KEY_W-1:0] NAME_SEVEN   = 64'h0067_6665_6463_6261;
  localparam logic [KEY_W-1:0] NAME_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] NAME_EMPTY   = 64'h0;
  localparam logic [KEY_W-1:0] EMPTY_JUNK   = 64'h0000_0000_0000_FF00;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;

  int fail_count;
  int awaiting;
  int checked;
  int full_refusals;
  int peak_total;
  int sent_total;

  logic [KEY_W-1:0] name_pool [POOL_SIZE];

  det_req_if req_ch ();
  det_rsp_if rsp_ch ();

  directory_entry_table_unit #(
    .CAPACITY   (CAPACITY),
    .NAME_BYTES (NAME_BYTES),
    .INODE_BITS (INODE_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  det_table_checker #(
    .CAPACITY   (CAPACITY),
    .NAME_BYTES (NAME_BYTES),
    .INODE_BITS (INODE_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_ch),
    .rsp_mon         (rsp_ch),
    .fail_count_o    (fail_count),
    .awaiting_o      (awaiting),
    .checked_o       (checked),
    .full_refusals_o (full_refusals),
    .peak_total_o    (peak_total)
  );

  always #10 clk_i = ~clk_i;

  // mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    if ($urandom_range(0, 99) < 88) return LEN_W'($urandom_range(0, NAME_BYTES - 1));
    return LEN_W'($urandom_range(NAME_BYTES, 255));
  endfunction

  // junk after the terminating zero byte must not change the name
  function automatic logic [KEY_W-1:0] scuff_name(logic [KEY_W-1:0] name);
    logic [KEY_W-1:0] out;
    int               zero_at;
    out     = name;
    zero_at = KEY_W / 8;
    for (int b = KEY_W / 8 - 1; b >= 0; b--) begin
      if (name[8*b +: 8] == 8'h00) zero_at = b;
    end
    if ($urandom_range(0, 1) == 1) begin
      for (int b = zero_at + 1; b < KEY_W / 8; b++) out[8*b +: 8] = 8'($urandom);
    end
    return out;
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [LEN_W-1:0] len, input logic [INODE_W-1:0] inode);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.name_key     <= key;
    req_ch.name_length  <= len;
    req_ch.inode_number <= inode;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_total++;
  endtask

  // response side back pressure
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] cand;
    logic [KEY_W-1:0] name;
    logic [OP_W-1:0]  op;
    int               nlen;
    int               roll;
    int               grow_ptr;
    int               drain_ptr;
    int               directed;
    bit               dup;
    bit               growing;

    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_LOOKUP;
    req_ch.name_key     <= '0;
    req_ch.name_length  <= '0;
    req_ch.inode_number <= '0;
    sent_total = 0;
    grow_ptr   = 0;
    drain_ptr  = 0;
    growing    = 1'b0;

    // distinct clean names: the empty name, one of full width, the rest random
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        nlen = (i == 0) ? 0 : (i == 1) ? NAME_BYTES : $urandom_range(1, NAME_BYTES);
        cand = '0;
        for (int b = 0; b < nlen; b++) cand[8*b +: 8] = 8'($urandom_range(1, 255));
        dup = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (name_pool[j] == cand) dup = 1'b1;
        end
      end while (dup);
      name_pool[i] = cand;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, limits of length and inode, duplicates, shifts
    send_op(OP_LOOKUP,  NAME_A,      8'd1,   8'd0);
    send_op(OP_DELETE,  NAME_A,      8'd1,   8'd0);
    send_op(OP_UNKNOWN, NAME_A,      8'd1,   8'd7);
    send_op(OP_PUT,     NAME_A,      8'd1,   8'd0);
    send_op(OP_PUT,     NAME_SEVEN,  8'd7,   8'd255);
    send_op(OP_PUT,     NAME_EMPTY,  8'd0,   8'h5A);
    send_op(OP_PUT,     NAME_ONES,   8'd7,   8'hA5);
    send_op(OP_PUT,     NAME_B,      8'd8,   8'd1);
    send_op(OP_PUT,     NAME_B,      8'd255, 8'd1);
    send_op(OP_PUT,     NAME_A,      8'd1,   8'd9);
    send_op(OP_PUT,     NAME_A_JUNK, 8'd1,   8'd9);
    send_op(OP_PUT,     EMPTY_JUNK,  8'd0,   8'd9);
    send_op(OP_LOOKUP,  NAME_A_JUNK, 8'd0,   8'd0);
    send_op(OP_LOOKUP,  NAME_SEVEN,  8'd0,   8'd0);
    send_op(OP_LOOKUP,  NAME_ONES,   8'd0,   8'd0);
    send_op(OP_LOOKUP,  NAME_B,      8'd0,   8'd0);
    send_op(OP_DELETE,  NAME_SEVEN,  8'd0,   8'd0);
    send_op(OP_LOOKUP,  NAME_EMPTY,  8'd0,   8'd0);
    send_op(OP_LOOKUP,  NAME_ONES,   8'd0,   8'd0);
    send_op(OP_DELETE,  NAME_A,      8'd0,   8'd0);
    send_op(OP_DELETE,  NAME_A,      8'd0,   8'd0);
    send_op(OP_UNKNOWN, NAME_ONES,   8'd255, 8'd255);
    send_op(OP_DELETE,  NAME_ONES,   8'd0,   8'd0);
    send_op(OP_DELETE,  EMPTY_JUNK,  8'd0,   8'd0);
    directed = sent_total;

    // random: phases that fill the table past full, then phases that drain it
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) growing = !growing;
      if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      op   = OP_LOOKUP;
      if (roll < 3) begin
        op = OP_UNKNOWN;
      end else if (roll < 5) begin
        op   = OP_W'($urandom_range(0, 3));
        name = {$urandom, $urandom};
      end else if (growing) begin
        if (roll < 70) begin
          op = OP_PUT;
          if ($urandom_range(0, 3) != 0) begin
            name     = name_pool[grow_ptr];
            grow_ptr = (grow_ptr + 1) % POOL_SIZE;
          end
        end else if (roll >= 85) begin
          op = OP_DELETE;
        end
      end else begin
        if (roll < 60) begin
          op = OP_DELETE;
          if ($urandom_range(0, 9) < 6) begin
            name      = name_pool[drain_ptr];
            drain_ptr = (drain_ptr + 1) % POOL_SIZE;
          end
        end else if (roll >= 85) begin
          op = OP_PUT;
        end
      end
      send_op(op, scuff_name(name), pick_length(), INODE_W'($urandom_range(0, 255)));
    end
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    while (awaiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d operations sent (%0d directed), %0d replies checked",
             sent_total, directed, checked);
    $display("table peaked at %0d entries, %0d puts refused for lack of room",
             peak_total, full_refusals);
    if (fail_count == 0) begin
      $display("** directory_entry_table_unit: PASSED **");
    end else begin
      $display("** directory_entry_table_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout: %0d replies still awaited", awaiting);
    $display("** directory_entry_table_unit: FAILED **");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/det_pkg.sv
rtl/core/det_req_if.sv
rtl/core/det_rsp_if.sv
rtl/core/det_entry_ram.sv
rtl/core/directory_entry_table_unit.sv
rtl/core/det_port_monitor.sv
tb/det_table_checker.sv
tb/tb_directory_entry_table_unit.sv
